@@ rtl/dct_pkg.sv @@
// Shared widths, constants and pipeline payload types of the conductance tensor block.
`default_nettype none
package dct_pkg;

   localparam int unsigned ANG_W = 16;
   localparam int unsigned SIG_W = 16;
   localparam int unsigned OUT_W = 24;
   localparam int unsigned CQ_W  = 17;
   localparam int unsigned C2_W  = 17;
   localparam int unsigned K_W   = 19;
   localparam int unsigned V_W   = 35;
   localparam int unsigned SQ_W  = 18;
   localparam int unsigned M_W   = 18;
   localparam int unsigned C_W   = 35;
   localparam int unsigned N_W   = 51;
   localparam int unsigned R_W   = 52;
   localparam int unsigned Q_W   = 24;
   localparam int unsigned LANES = 3;

   localparam logic [ANG_W:0]  ANGLE_FULL = 17'd65536;
   localparam logic [ANG_W-1:0] ANGLE_HALF = 16'd32768;
   localparam logic [30:0] PI_Q29  = 31'd1686629713;
   localparam logic [29:0] ONE_Q29 = 30'd536870912;
   localparam logic [C2_W-1:0] ONE_Q16 = 17'd65536;

   localparam int unsigned SH90 = 38;
   localparam logic [31:0] M90 = 32'(((64'd1 << SH90) + 64'd89) / 64'd90);
   localparam int unsigned HORNER_STEPS = 3;
   localparam int unsigned HSH [HORNER_STEPS] = '{37, 36, 35};
   localparam logic [31:0] HMUL [HORNER_STEPS] = '{
      32'(((64'd1 << 37) + 64'd55) / 64'd56),
      32'(((64'd1 << 36) + 64'd29) / 64'd30),
      32'(((64'd1 << 35) + 64'd11) / 64'd12)
   };

   localparam logic [OUT_W-1:0] U24_MAX     = 24'hFFFFFF;
   localparam logic [OUT_W-1:0] S24_POS_MAX = 24'h7FFFFF;
   localparam logic [OUT_W-1:0] S24_NEG_MAG = 24'h800000;

   localparam int unsigned LAT_COS   = 12;
   localparam int unsigned LAT_FRONT = 3;
   localparam int unsigned LAT_SQRT  = SQ_W;
   localparam int unsigned LAT_MID   = 2;
   localparam int unsigned LAT_DIV   = Q_W + 1;
   localparam int unsigned LAT_OUT   = 1;
   localparam int unsigned LAT_TOTAL =
      LAT_COS + LAT_FRONT + LAT_SQRT + LAT_MID + LAT_DIV + LAT_OUT;

   typedef struct packed {
      logic [SIG_W-1:0] par;
      logic [SIG_W-1:0] ped;
      logic [SIG_W-1:0] hall;
   } sig_type;

   typedef struct packed {
      logic    neg;
      sig_type sig;
   } cos_side_type;

   typedef struct packed {
      logic             neg;
      logic [CQ_W-1:0]  cq;
      logic [SIG_W-1:0] ped;
      logic [31:0]      ph;
      logic [C_W-1:0]   cdiv;
      logic [N_W-1:0]   n_th;
      logic [N_W-1:0]   n_ph;
   } sqrt_side_type;

   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [SIG_W-1:0] ped;
   } div_side_type;

   typedef struct packed {
      logic [LANES-1:0]          ovf;
      logic [LANES-1:0][Q_W-1:0] quo;
      div_side_type              side;
   } div_res_type;

endpackage
`default_nettype wire

@@ rtl/dct_if.sv @@
// Handshake interfaces for the grid point input words and the tensor result words.
`default_nettype none
interface dct_req_if import dct_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ANG_W-1:0] colatitude;
   logic [SIG_W-1:0] sigma_parallel;
   logic [SIG_W-1:0] sigma_pedersen;
   logic [SIG_W-1:0] sigma_hall;

   modport source (output valid, colatitude, sigma_parallel, sigma_pedersen, sigma_hall,
                   input ready);
   modport sink (input valid, colatitude, sigma_parallel, sigma_pedersen, sigma_hall,
                 output ready);
endinterface

interface dct_rsp_if import dct_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic        [OUT_W-1:0] tensor_thth;
   logic signed [OUT_W-1:0] tensor_thph;
   logic        [OUT_W-1:0] tensor_phph;
   logic                    divisor_zero;

   modport source (output valid, tensor_thth, tensor_thph, tensor_phph, divisor_zero,
                   input ready);
   modport sink (input valid, tensor_thth, tensor_thph, tensor_phph, divisor_zero,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/dct_cos.sv @@
// Pipelined cosine magnitude of the colatitude by a Horner series in Q29.
`default_nettype none
module dct_cos import dct_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [ANG_W-1:0]  angle,
   input  sig_type           sig_in,
   output logic [CQ_W-1:0]   cq,
   output cos_side_type      side_out
);

   cos_side_type     side_ff [LAT_COS];
   cos_side_type     side_in;
   logic [ANG_W-1:0] t_ff, t_in;
   logic [29:0]      r_ff, r_in;
   logic [46:0]      r_prod;
   logic [59:0]      z_prod;
   logic [30:0]      z_in;
   logic [30:0]      z_ff [8];
   logic [62:0]      q90_prod;
   logic [29:0]      p_in [HORNER_STEPS+1];
   logic [29:0]      p_ff [HORNER_STEPS+1];
   logic [30:0]      prod_in [HORNER_STEPS];
   logic [30:0]      prod_ff [HORNER_STEPS];
   logic [60:0]      f_prod;
   logic [30:0]      prod2_in, prod2_ff;
   logic [29:0]      half, pc;
   logic [CQ_W-1:0]  cq_in, cq_ff;

   assign side_in.neg = angle > ANGLE_HALF;
   assign side_in.sig = sig_in;
   assign t_in = side_in.neg ? ANG_W'(ANGLE_FULL - (ANG_W+1)'(angle)) : angle;

   assign r_prod = 47'(t_ff) * 47'(PI_Q29);
   assign r_in   = r_prod[45:16];
   assign z_prod = 60'(r_ff) * 60'(r_ff);
   assign z_in   = z_prod[59:29];

   assign q90_prod = 63'(z_ff[0]) * 63'(M90);
   assign p_in[0]  = ONE_Q29 - 30'(q90_prod >> SH90);

   for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
      logic [60:0] hp_prod;
      logic [62:0] hq_prod;
      assign hp_prod    = 61'(z_ff[2*j+1]) * 61'(p_ff[j]);
      assign prod_in[j] = hp_prod[59:29];
      assign hq_prod    = 63'(prod_ff[j]) * 63'(HMUL[j]);
      assign p_in[j+1]  = ONE_Q29 - 30'(hq_prod >> HSH[j]);
   end

   assign f_prod   = 61'(z_ff[7]) * 61'(p_ff[HORNER_STEPS]);
   assign prod2_in = f_prod[59:29];
   assign half     = prod2_ff[30:1];
   assign pc       = (half > ONE_Q29) ? '0 : ONE_Q29 - half;
   assign cq_in    = CQ_W'((31'(pc) + 31'd4096) >> 13);

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_in;
         r_ff     <= r_in;
         z_ff[0]  <= z_in;
         for (int i = 1; i < 8; i++) z_ff[i] <= z_ff[i-1];
         for (int i = 0; i <= HORNER_STEPS; i++) p_ff[i] <= p_in[i];
         for (int i = 0; i < HORNER_STEPS; i++) prod_ff[i] <= prod_in[i];
         prod2_ff <= prod2_in;
         cq_ff    <= cq_in;
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT_COS; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   assign cq       = cq_ff;
   assign side_out = side_ff[LAT_COS-1];

endmodule
`default_nettype wire

@@ rtl/dct_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module dct_sqrt import dct_pkg::*; (
   input  logic            clock,
   input  logic            adv,
   input  logic [K_W-1:0]  k,
   input  sqrt_side_type   side_in,
   output logic [SQ_W-1:0] sq,
   output sqrt_side_type   side_out
);

   logic [V_W-1:0]  rem_ff [SQ_W];
   logic [V_W-1:0]  rem_in [SQ_W];
   logic [SQ_W-1:0] res_ff [SQ_W];
   logic [SQ_W-1:0] res_in [SQ_W];
   sqrt_side_type   side_ff [SQ_W];

   for (genvar i = 0; i < SQ_W; i++) begin : g_step
      localparam int unsigned B = SQ_W - 1 - i;
      logic [V_W-1:0]  rem_prev;
      logic [SQ_W-1:0] res_prev;
      logic [V_W+1:0]  trial;
      logic            take;
      if (i == 0) begin : g_first
         assign rem_prev = {k, 16'b0};
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign res_prev = res_ff[i-1];
      end
      assign trial     = ((37'(res_prev) << 1) + (37'(1) << B)) << B;
      assign take      = 37'(rem_prev) >= trial;
      assign rem_in[i] = take ? rem_prev - V_W'(trial) : rem_prev;
      assign res_in[i] = take ? (res_prev | (SQ_W'(1) << B)) : res_prev;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < SQ_W; i++) begin
            rem_ff[i] <= rem_in[i];
            res_ff[i] <= res_in[i];
         end
         side_ff[0] <= side_in;
         for (int i = 1; i < SQ_W; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   assign sq       = res_ff[SQ_W-1];
   assign side_out = side_ff[SQ_W-1];

endmodule
`default_nettype wire

@@ rtl/dct_div.sv @@
// Pipelined rounding divider for three numerators over a shared divisor, with overflow flags.
`default_nettype none
module dct_div import dct_pkg::*; (
   input  logic           clock,
   input  logic           adv,
   input  logic [C_W-1:0] cdiv,
   input  logic [N_W-1:0] num [LANES],
   input  div_side_type   side_in,
   output div_res_type    res
);

   logic [R_W-1:0]   rem_ff [Q_W+1][LANES];
   logic [R_W-1:0]   rem_in [Q_W+1][LANES];
   logic [Q_W-1:0]   q_ff   [Q_W+1][LANES];
   logic [Q_W-1:0]   q_in   [Q_W+1][LANES];
   logic [LANES-1:0] ovf_ff [Q_W+1];
   logic [LANES-1:0] ovf_in;
   logic [C_W-1:0]   c_ff   [Q_W+1];
   div_side_type     side_ff [Q_W+1];

   for (genvar l = 0; l < LANES; l++) begin : g_pre
      logic [R_W-1:0] ns;
      assign ns           = R_W'(num[l]) + R_W'(cdiv >> 1);
      assign ovf_in[l]    = 59'(ns) >= (59'(cdiv) << Q_W);
      assign rem_in[0][l] = ns;
      assign q_in[0][l]   = '0;
   end

   for (genvar i = 1; i <= Q_W; i++) begin : g_step
      localparam int unsigned B = Q_W - i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [58:0] sh;
         logic        take;
         assign sh   = 59'(c_ff[i-1]) << B;
         assign take = 59'(rem_ff[i-1][l]) >= sh;
         assign rem_in[i][l] = take ? rem_ff[i-1][l] - R_W'(sh) : rem_ff[i-1][l];
         assign q_in[i][l]   = take ? (q_ff[i-1][l] | (Q_W'(1) << B)) : q_ff[i-1][l];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= Q_W; i++) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[i][l] <= rem_in[i][l];
               q_ff[i][l]   <= q_in[i][l];
            end
         end
         ovf_ff[0]  <= ovf_in;
         c_ff[0]    <= cdiv;
         side_ff[0] <= side_in;
         for (int i = 1; i <= Q_W; i++) begin
            ovf_ff[i]  <= ovf_ff[i-1];
            c_ff[i]    <= c_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      res.ovf  = ovf_ff[Q_W];
      res.side = side_ff[Q_W];
      for (int l = 0; l < LANES; l++) res.quo[l] = q_ff[Q_W][l];
   end

endmodule
`default_nettype wire

@@ rtl/dipole_conductance_tensor.sv @@
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// The divider, square root and cosine series are fully pipelined, one step per stage.
// Reset is synchronous and clears only the valid bits; data registers are not reset.
// Top level of the thin-shell ionosphere conductance tensor pipeline.
`default_nettype none
module dipole_conductance_tensor import dct_pkg::*; (
   input logic        clock,
   input logic        reset,
   dct_req_if.sink    req_ch,
   dct_rsp_if.source  rsp_ch
);

   logic [LAT_TOTAL-1:0] vld_ff;
   logic                 adv;

   logic [CQ_W-1:0] cq0;
   cos_side_type    side0;
   sig_type         sig_in;

   logic [CQ_W-1:0]  cq1_ff;
   logic [C2_W-1:0]  c2_ff, c2_in;
   logic [33:0]      c2_prod;
   cos_side_type     side1_ff;

   logic [C2_W-1:0]  s2_in, s2_ff;
   logic [K_W-1:0]   k_in, k_ff, k3_ff;
   logic [31:0]      pp_ff, hh_ff, ph_ff;
   logic [32:0]      a_ff, b_ff;
   logic [CQ_W-1:0]  cq2_ff;
   logic             neg2_ff;
   logic [SIG_W-1:0] ped2_ff;

   sqrt_side_type    side3_ff, side3_in;

   logic [SQ_W-1:0]  sq;
   sqrt_side_type    side_sq;
   logic [35:0]      m_prod;
   logic [M_W-1:0]   m_ff;
   sqrt_side_type    side4_ff;

   logic [C_W-1:0]   cdiv5_ff;
   logic [N_W-1:0]   num5_ff [LANES];
   div_side_type     dside5_ff, dside5_in;

   div_res_type      dres;
   logic [OUT_W-1:0] thth_in, thph_in, phph_in, mag;
   logic [OUT_W:0]   phsum;
   logic [OUT_W-1:0] thth_ff, thph_ff, phph_ff;
   logic             zero_ff;

   assign adv          = !vld_ff[LAT_TOTAL-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT_TOTAL-2:0], req_ch.valid};
      end
   end

   assign sig_in.par  = req_ch.sigma_parallel;
   assign sig_in.ped  = req_ch.sigma_pedersen;
   assign sig_in.hall = req_ch.sigma_hall;

   dct_cos u_cos (
      .clock    (clock),
      .adv      (adv),
      .angle    (req_ch.colatitude),
      .sig_in   (sig_in),
      .cq       (cq0),
      .side_out (side0)
   );

   assign c2_prod = 34'(cq0) * 34'(cq0) + 34'd32768;
   assign c2_in   = c2_prod[32:16];
   assign s2_in   = ONE_Q16 - c2_ff;
   assign k_in    = K_W'(ONE_Q16) + K_W'(c2_ff) * K_W'(3);

   always_comb begin
      side3_in.neg  = neg2_ff;
      side3_in.cq   = cq2_ff;
      side3_in.ped  = ped2_ff;
      side3_in.ph   = ph_ff;
      side3_in.cdiv = C_W'({a_ff, 2'b00}) + C_W'(b_ff);
      side3_in.n_th = N_W'(pp_ff) * N_W'(k_ff);
      side3_in.n_ph = N_W'(hh_ff) * N_W'(s2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cq1_ff   <= cq0;
         c2_ff    <= c2_in;
         side1_ff <= side0;
         s2_ff    <= s2_in;
         k_ff     <= k_in;
         pp_ff    <= 32'(side1_ff.sig.par) * 32'(side1_ff.sig.ped);
         hh_ff    <= 32'(side1_ff.sig.hall) * 32'(side1_ff.sig.hall);
         ph_ff    <= 32'(side1_ff.sig.par) * 32'(side1_ff.sig.hall);
         a_ff     <= 33'(side1_ff.sig.par) * 33'(c2_ff);
         b_ff     <= 33'(side1_ff.sig.ped) * 33'(s2_in);
         cq2_ff   <= cq1_ff;
         neg2_ff  <= side1_ff.neg;
         ped2_ff  <= side1_ff.sig.ped;
         side3_ff <= side3_in;
         k3_ff    <= k_ff;
      end
   end

   dct_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .k        (k3_ff),
      .side_in  (side3_ff),
      .sq       (sq),
      .side_out (side_sq)
   );

   assign m_prod = 36'(side_sq.cq) * 36'(sq) + 36'd32768;

   always_comb begin
      dside5_in.neg  = side4_ff.neg;
      dside5_in.ped  = side4_ff.ped;
      dside5_in.zero = side4_ff.cdiv == '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff       <= m_prod[33:16];
         side4_ff   <= side_sq;
         cdiv5_ff   <= side4_ff.cdiv;
         num5_ff[0] <= side4_ff.n_th;
         num5_ff[1] <= (N_W'(side4_ff.ph) * N_W'(m_ff)) << 1;
         num5_ff[2] <= side4_ff.n_ph;
         dside5_ff  <= dside5_in;
      end
   end

   dct_div u_div (
      .clock   (clock),
      .adv     (adv),
      .cdiv    (cdiv5_ff),
      .num     (num5_ff),
      .side_in (dside5_ff),
      .res     (dres)
   );

   always_comb begin
      thth_in = dres.ovf[0] ? U24_MAX : dres.quo[0];
      if (dres.side.neg) begin
         mag = (dres.ovf[1] || dres.quo[1] > S24_NEG_MAG) ? S24_NEG_MAG : dres.quo[1];
         thph_in = OUT_W'(0) - mag;
      end else begin
         mag = (dres.ovf[1] || dres.quo[1] > S24_POS_MAX) ? S24_POS_MAX : dres.quo[1];
         thph_in = mag;
      end
      phsum = (OUT_W+1)'(dres.side.ped) + (OUT_W+1)'(dres.quo[2]);
      phph_in = (dres.ovf[2] || phsum > (OUT_W+1)'(U24_MAX)) ? U24_MAX : phsum[OUT_W-1:0];
      if (dres.side.zero) begin
         thth_in = '0;
         thph_in = '0;
         phph_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         thth_ff <= thth_in;
         thph_ff <= thph_in;
         phph_ff <= phph_in;
         zero_ff <= dres.side.zero;
      end
   end

   assign rsp_ch.valid        = vld_ff[LAT_TOTAL-1];
   assign rsp_ch.tensor_thth  = thth_ff;
   assign rsp_ch.tensor_thph  = signed'(thph_ff);
   assign rsp_ch.tensor_phph  = phph_ff;
   assign rsp_ch.divisor_zero = zero_ff;

endmodule
`default_nettype wire

@@ rtl/dct_checker.sv @@
// Port-level assertions for the conductance tensor block, bound to its top level.
`default_nettype none
module dct_checker import dct_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] thth,
   input logic [OUT_W-1:0] thph,
   input logic [OUT_W-1:0] phph,
   input logic             dzero
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dzero) |-> (thth == '0 && thph == '0 && phph == '0))
      else $error("zero divisor word carries nonzero components");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(thth) && $stable(thph) && $stable(phph) && $stable(dzero)))
      else $error("result word changed while stalled");

endmodule

bind dipole_conductance_tensor dct_checker u_dct_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .thth      (rsp_ch.tensor_thth),
   .thph      (rsp_ch.tensor_thph),
   .phph      (rsp_ch.tensor_phph),
   .dzero     (rsp_ch.divisor_zero)
);
`default_nettype wire
